// ===== rtl/dgm_pkg.sv =====
package dgm_pkg;

    localparam int MaxDim = 1024;
    localparam int DimW = $clog2(MaxDim + 1);
    localparam int IdxW = 20;
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);
    localparam int DivW = 37;
    localparam int DivCntW = $clog2(DivW + 1);

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_FACE   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_OFFSET    = 3'd0,
        REG_SCALE     = 3'd1,
        REG_COL_CTR   = 3'd2,
        REG_ROW_CTR   = 3'd3,
        REG_COLS      = 3'd4,
        REG_ROWS      = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic signed [15:0] disparity;
        logic [9:0]         grid_row;
        logic [9:0]         grid_col;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [19:0]        corner_a;
        logic [19:0]        corner_b;
        logic [19:0]        corner_c;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [16:0] den;
        logic signed [31:0] num_x;
        logic signed [31:0] num_y;
        logic signed [36:0] num_z;
        logic               faces;
        logic [IdxW-1:0]    v00;
        logic [DimW-1:0]    cols;
    } t_job;

endpackage

// ===== rtl/dgm_front.sv =====
module dgm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_take,
    input  dgm_pkg::t_in_item  i_item,
    output dgm_pkg::t_job      o_job
);
    import dgm_pkg::*;

    logic signed [15:0] r_offset;
    logic [23:0]        r_scale;
    logic [9:0]         r_col_ctr;
    logic [9:0]         r_row_ctr;
    logic [10:0]        r_cols;
    logic [10:0]        r_rows;
    logic [DimW-1:0]    cols;
    logic [DimW-1:0]    rows;
    logic [IdxW+DimW-1:0] prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_scale   <= 24'd256;
            r_col_ctr <= '0;
            r_row_ctr <= '0;
            r_cols    <= 11'd640;
            r_rows    <= 11'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OFFSET:  r_offset  <= i_cfg_data[15:0];
                REG_SCALE:   r_scale   <= i_cfg_data[23:0];
                REG_COL_CTR: r_col_ctr <= i_cfg_data[9:0];
                REG_ROW_CTR: r_row_ctr <= i_cfg_data[9:0];
                REG_COLS:    r_cols    <= i_cfg_data[10:0];
                REG_ROWS:    r_rows    <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cols < 11'd2) cols = DimW'(2);
        else if (r_cols > 11'(MaxDim)) cols = DimW'(MaxDim);
        else cols = DimW'(r_cols);
        if (r_rows < 11'd2) rows = DimW'(2);
        else if (r_rows > 11'(MaxDim)) rows = DimW'(MaxDim);
        else rows = DimW'(r_rows);
        prod = (IdxW+DimW)'(i_item.grid_row) * (IdxW+DimW)'(cols);
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            o_job.den   <= 17'(i_item.disparity) + 17'(r_offset);
            o_job.num_x <= {2'b00, r_col_ctr, 20'd0} - {2'b00, i_item.grid_col, 20'd0};
            o_job.num_y <= {2'b00, r_row_ctr, 20'd0} - {2'b00, i_item.grid_row, 20'd0};
            o_job.num_z <= -$signed({1'b0, r_scale, 12'd0});
            o_job.faces <= ((DimW+1)'(i_item.grid_row) + 1'b1 < (DimW+1)'(rows))
                        && ((DimW+1)'(i_item.grid_col) + 1'b1 < (DimW+1)'(cols));
            o_job.v00   <= prod[IdxW-1:0] + IdxW'(i_item.grid_col);
            o_job.cols  <= cols;
        end
    end
endmodule

// ===== rtl/dgm_queue.sv =====
module dgm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dgm_pkg::t_job  i_job,
    input  logic           i_pop,
    output dgm_pkg::t_job  o_job,
    output logic           o_empty,
    output logic           o_full,
    output logic           o_afull
);
    import dgm_pkg::*;

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QPtrW:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_afull = (r_cnt == (QPtrW+1)'(QDepth - 1));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(i_push) - (QPtrW+1)'(i_pop);
        end
    end
endmodule

// ===== rtl/dgm_div.sv =====
module dgm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [dgm_pkg::DivW-1:0] i_num,
    input  logic signed [16:0]              i_den,
    output logic                            o_done,
    output logic signed [31:0]              o_quot
);
    import dgm_pkg::*;

    logic [DivW-1:0]    r_q;
    logic [DivW:0]      r_rem;
    logic [16:0]        r_d;
    logic               r_neg;
    logic               r_busy;
    logic [DivCntW-1:0] r_cnt;
    logic [DivW:0]      trial;
    logic [DivW:0]      shifted;
    logic signed [DivW:0] sq;

    always_comb begin
        shifted = {r_rem[DivW-1:0], r_q[DivW-1]};
        trial   = shifted - (DivW+1)'(r_d);
        sq      = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DivCntW'(DivW);
                r_rem  <= '0;
                r_q    <= i_num[DivW-1] ? DivW'(-i_num) : DivW'(i_num);
                r_d    <= i_den[16] ? 17'(-i_den) : 17'(i_den);
                r_neg  <= i_num[DivW-1] ^ i_den[16];
            end else if (r_busy) begin
                if (!trial[DivW]) begin
                    r_rem <= trial;
                    r_q   <= {r_q[DivW-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q   <= {r_q[DivW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DivCntW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (sq > $signed((DivW+1)'(32'h7FFFFFFF))) o_quot = 32'sh7FFFFFFF;
        else if (sq < -$signed((DivW+1)'(33'h80000000))) o_quot = 32'sh80000000;
        else o_quot = sq[31:0];
    end
endmodule

// ===== rtl/dgm_back.sv =====
module dgm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  dgm_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    output dgm_pkg::t_out_item o_item
);
    import dgm_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [1:0]  r_step, n_step;
    logic signed [31:0] r_x, r_y, r_z;
    logic        div_start;
    logic [2:0]  div_done;
    logic signed [31:0] quot [3];
    logic signed [DivW-1:0] nums [3];
    logic        n_valid;
    t_out_item   n_item;
    logic [IdxW-1:0] v01, v10, v11;

    assign nums[0] = DivW'(i_job.num_x);
    assign nums[1] = DivW'(i_job.num_y);
    assign nums[2] = i_job.num_z;
    assign div_start = (r_state == ST_IDLE) && !i_empty && (i_job.den != '0);

    for (genvar g = 0; g < 3; g++) begin : g_div
        dgm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (nums[g]),
            .i_den   (i_job.den),
            .o_done  (div_done[g]),
            .o_quot  (quot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (&div_done) begin
            r_x <= quot[0];
            r_y <= quot[1];
            r_z <= quot[2];
        end
        o_item <= n_item;
    end

    assign v01 = r_job.v00 + 1'b1;
    assign v10 = r_job.v00 + IdxW'(r_job.cols);
    assign v11 = v10 + 1'b1;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_pop   = 1'b0;
        n_valid = 1'b0;
        n_item  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.den == '0) begin
                        n_valid     = 1'b1;
                        n_item.kind = KIND_ERROR;
                        n_item.last = 1'b1;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (&div_done) begin
                    n_state = ST_EMIT;
                    n_step  = 2'd0;
                end
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                n_step  = r_step + 1'b1;
                case (r_step)
                    2'd0: begin
                        n_item.kind  = KIND_VERTEX;
                        n_item.pos_x = r_x;
                        n_item.pos_y = r_y;
                        n_item.pos_z = r_z;
                        n_item.last  = !r_job.faces;
                        if (!r_job.faces) n_state = ST_IDLE;
                    end
                    2'd1: begin
                        n_item.kind     = KIND_FACE;
                        n_item.corner_a = r_job.v00;
                        n_item.corner_b = v01;
                        n_item.corner_c = v10;
                    end
                    default: begin
                        n_item.kind     = KIND_FACE;
                        n_item.corner_a = v10;
                        n_item.corner_b = v01;
                        n_item.corner_c = v11;
                        n_item.last     = 1'b1;
                        n_state         = ST_IDLE;
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/disparity_to_grid_mesh_core.sv =====
// Disparity to grid mesh reprojection.
// Input: raise start with an item while busy is low; the beat is taken
// on that edge. The front stage registers the item, forms the denominator,
// the numerators (x, y in Q12.20), the face test and the cell's first vertex
// index, and pushes a job into a four-entry queue; busy rises when it would fill.
// Back end: three 37-step restoring dividers run in parallel for x, y, z.
// A job with faces yields a vertex and two faces on consecutive cycles,
// otherwise a vertex alone; a zero denominator yields one error beat.
// A vertex passes the front register, the queue, the dividers and the output
// register; an error beat skips the dividers. Sustained throughput is set by the
// dividers, while the queue keeps taking items; one item per cycle with a zero denominator.
// Results appear for one cycle with o_valid high, o_item.last on the
// final beat of each item. The receiver cannot stall; results never wait.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready
// is always high. Write only while idle.
// Reset (synchronous, active low) restores register defaults and empties
// the queue and the back end.
module disparity_to_grid_mesh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dgm_pkg::t_in_item  i_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output dgm_pkg::t_out_item o_item
);
    import dgm_pkg::*;

    t_job job_f, job_q;
    logic take, r_push, pop, empty, full, afull;

    assign busy = full || (r_push && afull);
    assign take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_push <= 1'b0;
        else r_push <= take;
    end

    dgm_front u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_take (take), .i_item, .o_job (job_f)
    );

    dgm_queue u_queue (
        .i_clk, .i_rst_n, .i_push (r_push), .i_job (job_f), .i_pop (pop),
        .o_job (job_q), .o_empty (empty), .o_full (full), .o_afull (afull)
    );

    dgm_back u_back (
        .i_clk, .i_rst_n, .i_empty (empty), .i_job (job_q), .o_pop (pop),
        .o_valid, .o_item
    );
endmodule

// ===== rtl/dgm_checker.sv =====
module dgm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input dgm_pkg::t_out_item o_item
);
    import dgm_pkg::*;

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.kind != 2'd3) else $error("bad kind");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == KIND_ERROR |-> o_item.last) else $error("err last");
    a_face_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == KIND_FACE |-> o_item.pos_x == 0 && o_item.pos_z == 0)
        else $error("face pos");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_hs_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({start, busy})) else $error("handshake unknown");
endmodule

bind disparity_to_grid_mesh_core dgm_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_item
);
